// ===== sv/lje_pkg.sv =====
`default_nettype none
package lje_pkg;

   // Item classes decided by the front end
   localparam logic [1:0] CLS_PLAIN   = 2'd0;
   localparam logic [1:0] CLS_SHORT   = 2'd1;
   localparam logic [1:0] CLS_UNICODE = 2'd2;
   localparam logic [1:0] CLS_HIGH    = 2'd3;

   localparam int unsigned IDX_W = 3;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;

   // One classified request held between front and back
   typedef struct packed {
      logic [1:0] cls;
      logic [7:0] data;   // escape letter for short escapes, else the input byte
   } cmd_type;

   // Queue status seen by the top level and the back end
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = CH_ZERO + {4'd0, nib};
      end else begin
         d = 8'h57 + {4'd0, nib};
      end
      return d;
   endfunction

   // Index of the final output byte for a class
   function automatic logic [IDX_W-1:0] last_idx(input logic [1:0] cls);
      logic [IDX_W-1:0] n;
      unique case (cls)
         CLS_PLAIN:   n = IDX_W'(0);
         CLS_SHORT:   n = IDX_W'(1);
         CLS_UNICODE: n = IDX_W'(5);
         CLS_HIGH:    n = IDX_W'(1);
         default:     n = IDX_W'(0);
      endcase
      return n;
   endfunction

   // Output byte at a given position of the escaped sequence
   function automatic logic [7:0] byte_at(input cmd_type cmd, input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      b = cmd.data;
      unique case (cmd.cls)
         CLS_PLAIN: b = cmd.data;
         CLS_SHORT: b = (idx == IDX_W'(0)) ? CH_BACKSLASH : cmd.data;
         CLS_UNICODE: begin
            case (idx)
               IDX_W'(0): b = CH_BACKSLASH;
               IDX_W'(1): b = CH_LOWER_U;
               IDX_W'(2): b = CH_ZERO;
               IDX_W'(3): b = CH_ZERO;
               IDX_W'(4): b = hex_digit(cmd.data[7:4]);
               default:   b = hex_digit(cmd.data[3:0]);
            endcase
         end
         CLS_HIGH: begin
            if (idx == IDX_W'(0)) begin
               b = {6'b110000, cmd.data[7:6]};
            end else begin
               b = {2'b10, cmd.data[5:0]};
            end
         end
         default: b = cmd.data;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== sv/latin1_to_json_utf8_escaper.sv =====
`default_nettype none
// Channel     | Ports                                   | Handshake
// ------------+-----------------------------------------+------------------------
// request in  | req_latin_byte[7:0]                     | req_push / req_full
// result out  | rsp_out_byte[7:0], rsp_run_last         | rsp_empty / rsp_pop
//
// Each request yields 1, 2 or 6 result bytes; the back end emits one byte per cycle
// while the output register is empty or being popped, and holds otherwise.
// Plain ASCII thus runs at one request per cycle; the output register bounds the rate.
// The command queue (QUEUE_DEPTH entries) lets requests enter while escapes drain.
// Synchronous active-high reset empties the queue and the output register.
// A stalled result holds its byte until popped; requests stall only when the queue is full.
module latin1_to_json_utf8_escaper #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_latin_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);
   import lje_pkg::*;

   cmd_type      front_cmd;
   cmd_type      head_cmd;
   q_status_type q_status;
   logic         head_done;

   assign req_full = q_status.full;

   lje_front u_front (
      .latin_byte (req_latin_byte),
      .cmd        (front_cmd)
   );

   lje_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (req_push),
      .wr_cmd (front_cmd),
      .rd_en  (head_done),
      .rd_cmd (head_cmd),
      .status (q_status)
   );

   lje_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .q_status     (q_status),
      .head_done    (head_done),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule
`default_nettype wire

// ===== sv/lje_front.sv =====
`default_nettype none
module lje_front (
   input  wire logic [7:0]      latin_byte,
   output lje_pkg::cmd_type     cmd
);
   import lje_pkg::*;

   // Classify the byte and pick the short escape letter
   always_comb begin
      cmd.data = latin_byte;
      unique case (latin_byte)
         CH_QUOTE, CH_BACKSLASH, CH_SLASH: begin
            cmd.cls = CLS_SHORT;
         end
         8'h08: begin cmd.cls = CLS_SHORT; cmd.data = 8'h62; end
         8'h0C: begin cmd.cls = CLS_SHORT; cmd.data = 8'h66; end
         8'h0A: begin cmd.cls = CLS_SHORT; cmd.data = 8'h6E; end
         8'h0D: begin cmd.cls = CLS_SHORT; cmd.data = 8'h72; end
         8'h09: begin cmd.cls = CLS_SHORT; cmd.data = 8'h74; end
         default: begin
            if (latin_byte <= CTRL_MAX) begin
               cmd.cls = CLS_UNICODE;
            end else if (latin_byte[7]) begin
               cmd.cls = CLS_HIGH;
            end else begin
               cmd.cls = CLS_PLAIN;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/lje_queue.sv =====
`default_nettype none
module lje_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire lje_pkg::cmd_type    wr_cmd,
   input  wire logic                rd_en,
   output lje_pkg::cmd_type         rd_cmd,
   output lje_pkg::q_status_type    status
);
   import lje_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == CNT_W'(0));
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_cmd       = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lje_back.sv =====
`default_nettype none
module lje_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lje_pkg::cmd_type    head_cmd,
   input  wire lje_pkg::q_status_type q_status,
   output logic                     head_done,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last
);
   import lje_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             take, advance, is_last;

   assign take    = rsp_pop && out_valid_ff;
   assign advance = !q_status.empty && (!out_valid_ff || take);
   assign is_last = (idx_ff == last_idx(head_cmd.cls));

   assign head_done    = advance && is_last;
   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   // Emit one head byte per cycle to the output register unless stalled
   always_comb begin
      out_valid_in = out_valid_ff && !take;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      idx_in       = idx_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_at(head_cmd, idx_ff);
         out_last_in  = is_last;
         idx_in       = is_last ? IDX_W'(0) : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold payload until the next advance
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule
`default_nettype wire

// ===== sv/lje_checker.sv =====
`default_nettype none
module lje_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_run_last
);

   // Reset leaves no result and room for requests
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or full flag present after reset");

   // A waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("waiting result changed before pop");

   // The rest of a sequence follows right after a non-final byte is popped
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_run_last |=> !rsp_empty)
      else $error("gap inside an escape sequence");

   // Only escape heads, hex digits and UTF-8 lead bytes may be non-final
   a_nonlast_byte: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_run_last |->
         rsp_out_byte == 8'h5C || rsp_out_byte == 8'h75 || rsp_out_byte == 8'h30 ||
         rsp_out_byte == 8'h31 || rsp_out_byte == 8'hC2 || rsp_out_byte == 8'hC3)
      else $error("unexpected non-final byte");

endmodule

bind latin1_to_json_utf8_escaper lje_checker u_lje_checker (.*);
`default_nettype wire
